@@ sv/image_rotate_forward_map_unit_defines.svh @@
// assertion macros shared by the image rotate forward map rtl
`ifndef IMAGE_ROTATE_FORWARD_MAP_UNIT_DEFINES_SVH
`define IMAGE_ROTATE_FORWARD_MAP_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clock, off while reset is high
`define IRFM_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("irfm assertion failed");

// next-cycle implication, sampled on clock, off while reset is high
`define IRFM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("irfm assertion failed");

`else

`define IRFM_ASSERT(label, ante, cons)
`define IRFM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ sv/irfm_pkg.sv @@
// types, constants and the sine table of the image rotate forward map unit
package irfm_pkg;

   // field and register widths
   localparam int COORD_W = 12;
   localparam int DIM_W = 13;
   localparam int PIX_W = 24;
   localparam int ANGLE_W = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 13;

   // fixed point trig values
   localparam int TRIG_FRAC_BITS = 16;
   localparam int TRIG_W = 18;
   localparam int TAB_W = 17;
   localparam int DEG_W = 7;
   localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

   // largest image side
   localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ANGLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] src_row;
      logic [COORD_W-1:0] src_col;
      logic [PIX_W-1:0] pixel_value;
   } req_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0] dest_row;
      logic [COORD_W-1:0] dest_col;
      logic [PIX_W-1:0] pixel_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_val;
      logic signed [TRIG_W-1:0] cos_val;
   } trig_type;

   // sine of 0..90 whole degrees, rounded to 16 fraction bits
   function automatic logic [TAB_W-1:0] sin_deg(input logic [DEG_W-1:0] deg);
      logic [TAB_W-1:0] v;
      case (deg)
         7'd0: v = 17'd0;
         7'd1: v = 17'd1144;
         7'd2: v = 17'd2287;
         7'd3: v = 17'd3430;
         7'd4: v = 17'd4572;
         7'd5: v = 17'd5712;
         7'd6: v = 17'd6850;
         7'd7: v = 17'd7987;
         7'd8: v = 17'd9121;
         7'd9: v = 17'd10252;
         7'd10: v = 17'd11380;
         7'd11: v = 17'd12505;
         7'd12: v = 17'd13626;
         7'd13: v = 17'd14742;
         7'd14: v = 17'd15855;
         7'd15: v = 17'd16962;
         7'd16: v = 17'd18064;
         7'd17: v = 17'd19161;
         7'd18: v = 17'd20252;
         7'd19: v = 17'd21336;
         7'd20: v = 17'd22415;
         7'd21: v = 17'd23486;
         7'd22: v = 17'd24550;
         7'd23: v = 17'd25607;
         7'd24: v = 17'd26656;
         7'd25: v = 17'd27697;
         7'd26: v = 17'd28729;
         7'd27: v = 17'd29753;
         7'd28: v = 17'd30767;
         7'd29: v = 17'd31772;
         7'd30: v = 17'd32768;
         7'd31: v = 17'd33754;
         7'd32: v = 17'd34729;
         7'd33: v = 17'd35693;
         7'd34: v = 17'd36647;
         7'd35: v = 17'd37590;
         7'd36: v = 17'd38521;
         7'd37: v = 17'd39441;
         7'd38: v = 17'd40348;
         7'd39: v = 17'd41243;
         7'd40: v = 17'd42126;
         7'd41: v = 17'd42995;
         7'd42: v = 17'd43852;
         7'd43: v = 17'd44695;
         7'd44: v = 17'd45525;
         7'd45: v = 17'd46341;
         7'd46: v = 17'd47143;
         7'd47: v = 17'd47930;
         7'd48: v = 17'd48703;
         7'd49: v = 17'd49461;
         7'd50: v = 17'd50203;
         7'd51: v = 17'd50931;
         7'd52: v = 17'd51643;
         7'd53: v = 17'd52339;
         7'd54: v = 17'd53020;
         7'd55: v = 17'd53684;
         7'd56: v = 17'd54332;
         7'd57: v = 17'd54963;
         7'd58: v = 17'd55578;
         7'd59: v = 17'd56175;
         7'd60: v = 17'd56756;
         7'd61: v = 17'd57319;
         7'd62: v = 17'd57865;
         7'd63: v = 17'd58393;
         7'd64: v = 17'd58903;
         7'd65: v = 17'd59396;
         7'd66: v = 17'd59870;
         7'd67: v = 17'd60326;
         7'd68: v = 17'd60764;
         7'd69: v = 17'd61183;
         7'd70: v = 17'd61584;
         7'd71: v = 17'd61966;
         7'd72: v = 17'd62328;
         7'd73: v = 17'd62672;
         7'd74: v = 17'd62997;
         7'd75: v = 17'd63303;
         7'd76: v = 17'd63589;
         7'd77: v = 17'd63856;
         7'd78: v = 17'd64104;
         7'd79: v = 17'd64332;
         7'd80: v = 17'd64540;
         7'd81: v = 17'd64729;
         7'd82: v = 17'd64898;
         7'd83: v = 17'd65048;
         7'd84: v = 17'd65177;
         7'd85: v = 17'd65287;
         7'd86: v = 17'd65376;
         7'd87: v = 17'd65446;
         7'd88: v = 17'd65496;
         7'd89: v = 17'd65526;
         7'd90: v = 17'd65536;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/image_rotate_forward_map_unit.sv @@
// top level of the image rotate forward map unit: registers, pipeline and handshakes
//
//   port group   direction   carries
//   req_*        in          source row, column and pixel, valid/stall
//   rsp_*        out         destination row, column and pixel, valid/stall
//   csr_*        in          register writes: angle, rows, cols
//
// one request per cycle sustained while rsp_stall is low; three register stages (input, products,
// result): each request is registered at the input, then as its products, then as its result.
// the four 14x18 coordinate products sit between the input and product registers.
// reset is synchronous; trig values and image size come back to angle 0, 4096x4096.
// each stage loads whenever it is empty or the one after it moves, so stalls on the
// result side back up only as far as there are full stages.
`include "image_rotate_forward_map_unit_defines.svh"

module image_rotate_forward_map_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  irfm_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output irfm_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_write,
   input  logic [irfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irfm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PROD_W = 32;
   localparam int SUM_W = 34;
   localparam int OFS_W = irfm_pkg::COORD_W + 2;
   localparam int HALF_W = irfm_pkg::DIM_W - 1;

   // configuration state
   logic [irfm_pkg::DIM_W-1:0]          rows_ff, rows_in;
   logic [irfm_pkg::DIM_W-1:0]          cols_ff, cols_in;
   logic signed [irfm_pkg::TRIG_W-1:0]  sin_ff, sin_in;
   logic signed [irfm_pkg::TRIG_W-1:0]  cos_ff, cos_in;
   irfm_pkg::trig_type                  trig_new;
   logic [irfm_pkg::DIM_W-1:0]          dim_wr;

   // pipeline state
   logic                                s1_valid_ff, s1_valid_in;
   irfm_pkg::req_payload_type           s1_req_ff;
   logic                                s2_valid_ff, s2_valid_in;
   logic signed [PROD_W-1:0]            xs_ff, xc_ff, ys_ff, yc_ff;
   logic signed [PROD_W-1:0]            xs_in, xc_in, ys_in, yc_in;
   logic [irfm_pkg::PIX_W-1:0]          s2_pix_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   irfm_pkg::rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic                                rsp_ready, s2_ready, s1_ready;
   logic                                in_range;
   logic signed [OFS_W-1:0]             x_ofs, y_ofs;
   logic signed [SUM_W-1:0]             row_num, col_num;
   logic [irfm_pkg::DIM_W-1:0]          row_axis, col_axis;

   // truncate toward zero and range check one axis; msb is the hit flag
   function automatic logic [irfm_pkg::DIM_W-1:0] axis_map(
      input logic signed [SUM_W-1:0] num,
      input logic [irfm_pkg::DIM_W-1:0] dim
   );
      logic [SUM_W-irfm_pkg::TRIG_FRAC_BITS-1:0] whole;
      logic hit;
      logic [irfm_pkg::COORD_W-1:0] coord;
      whole = num[SUM_W-1:irfm_pkg::TRIG_FRAC_BITS];
      if (!num[SUM_W-1]) begin
         hit = whole < {{(SUM_W-irfm_pkg::TRIG_FRAC_BITS-irfm_pkg::DIM_W){1'b0}}, dim};
         coord = whole[irfm_pkg::COORD_W-1:0];
      end else begin
         // a value in (-1, 0) truncates to zero
         hit = (&whole) && (num[irfm_pkg::TRIG_FRAC_BITS-1:0] != '0);
         coord = '0;
      end
      return {hit, coord};
   endfunction

   // trig lookup for the angle being written
   irfm_trig u_trig (
      .angle (csr_wdata[irfm_pkg::ANGLE_W-1:0]),
      .trig  (trig_new)
   );

   // register writes, image size clamped to the largest side
   always_comb begin
      dim_wr = (csr_wdata > irfm_pkg::MAX_DIM) ? irfm_pkg::MAX_DIM : csr_wdata;
      rows_in = rows_ff;
      cols_in = cols_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      if (csr_write) begin
         case (csr_index)
            irfm_pkg::CSR_ANGLE: begin
               sin_in = trig_new.sin_val;
               cos_in = trig_new.cos_val;
            end
            irfm_pkg::CSR_ROWS: rows_in = dim_wr;
            irfm_pkg::CSR_COLS: cols_in = dim_wr;
            default: begin
               rows_in = rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= irfm_pkg::MAX_DIM;
         cols_ff <= irfm_pkg::MAX_DIM;
         sin_ff <= '0;
         cos_ff <= irfm_pkg::TRIG_ONE;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   // stage readiness, back to front
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready = !s2_valid_ff || rsp_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   // input stage
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_req_ff <= req_payload;
      end
   end

   // source range check and centered offsets
   assign in_range = ({1'b0, s1_req_ff.src_row} < rows_ff) &&
                     ({1'b0, s1_req_ff.src_col} < cols_ff);
   assign x_ofs = $signed({2'b00, s1_req_ff.src_col}) -
                  $signed({2'b00, cols_ff[irfm_pkg::DIM_W-1:1]});
   assign y_ofs = $signed({2'b00, s1_req_ff.src_row}) -
                  $signed({2'b00, rows_ff[irfm_pkg::DIM_W-1:1]});

   // rotation products
   assign xs_in = PROD_W'(x_ofs) * PROD_W'(sin_ff);
   assign xc_in = PROD_W'(x_ofs) * PROD_W'(cos_ff);
   assign ys_in = PROD_W'(y_ofs) * PROD_W'(sin_ff);
   assign yc_in = PROD_W'(y_ofs) * PROD_W'(cos_ff);

   // product stage, sources outside the image are dropped here
   assign s2_valid_in = s2_ready ? (s1_valid_ff && in_range) : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         xs_ff <= xs_in;
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         yc_ff <= yc_in;
         s2_pix_ff <= s1_req_ff.pixel_value;
      end
   end

   // sums with the center added back
   assign row_num = SUM_W'(yc_ff) - SUM_W'(xs_ff) +
                    $signed({{(SUM_W-HALF_W-irfm_pkg::TRIG_FRAC_BITS){1'b0}},
                             rows_ff[irfm_pkg::DIM_W-1:1],
                             {irfm_pkg::TRIG_FRAC_BITS{1'b0}}});
   assign col_num = SUM_W'(xc_ff) + SUM_W'(ys_ff) +
                    $signed({{(SUM_W-HALF_W-irfm_pkg::TRIG_FRAC_BITS){1'b0}},
                             cols_ff[irfm_pkg::DIM_W-1:1],
                             {irfm_pkg::TRIG_FRAC_BITS{1'b0}}});
   assign row_axis = axis_map(row_num, rows_ff);
   assign col_axis = axis_map(col_num, cols_ff);

   // result stage, destinations outside the image are dropped here
   always_comb begin
      rsp_payload_in.dest_row = row_axis[irfm_pkg::COORD_W-1:0];
      rsp_payload_in.dest_col = col_axis[irfm_pkg::COORD_W-1:0];
      rsp_payload_in.pixel_out = s2_pix_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = s2_valid_ff && row_axis[irfm_pkg::DIM_W-1] &&
                        col_axis[irfm_pkg::DIM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready && s2_valid_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `IRFM_ASSERT(a_trig_bounded, 1'b1, (sin_ff <= irfm_pkg::TRIG_ONE) && (sin_ff >= -irfm_pkg::TRIG_ONE) && (cos_ff <= irfm_pkg::TRIG_ONE) && (cos_ff >= -irfm_pkg::TRIG_ONE))
   `IRFM_ASSERT_NEXT(a_zero_angle, csr_write && (csr_index == irfm_pkg::CSR_ANGLE) && (csr_wdata[irfm_pkg::ANGLE_W-1:0] == '0), (cos_ff == irfm_pkg::TRIG_ONE) && (sin_ff == '0))
   `IRFM_ASSERT(a_dest_inside, rsp_valid_ff, (rsp_payload_ff.dest_row < rows_ff) && (rsp_payload_ff.dest_col < cols_ff))
   `IRFM_ASSERT(a_stall_only_full, req_stall, s1_valid_ff && s2_valid_ff && rsp_valid_ff)
   `IRFM_ASSERT_NEXT(a_bubble_empties, !s2_valid_ff && rsp_ready, !rsp_valid_ff)

endmodule

@@ sv/irfm_trig.sv @@
// angle to signed sine and cosine lookup with quadrant folding
module irfm_trig (
   input  logic [irfm_pkg::ANGLE_W-1:0] angle,
   output irfm_pkg::trig_type           trig
);

   localparam logic [irfm_pkg::ANGLE_W-1:0] DEG_FULL = 9'd360;
   localparam logic [irfm_pkg::ANGLE_W-1:0] DEG_90 = 9'd90;
   localparam logic [irfm_pkg::ANGLE_W-1:0] DEG_180 = 9'd180;
   localparam logic [irfm_pkg::ANGLE_W-1:0] DEG_270 = 9'd270;
   localparam logic [irfm_pkg::DEG_W-1:0] DEG_RIGHT = 7'd90;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   logic [irfm_pkg::ANGLE_W-1:0] angle_red;
   logic [irfm_pkg::ANGLE_W-1:0] angle_rem;
   quad_type                     quad;
   logic [irfm_pkg::TAB_W-1:0]   sin_mag;
   logic [irfm_pkg::TAB_W-1:0]   cos_mag;
   logic signed [irfm_pkg::TRIG_W-1:0] sin_pos;
   logic signed [irfm_pkg::TRIG_W-1:0] cos_pos;

   // reduce to one turn, then split into quadrant and remainder
   always_comb begin
      angle_red = (angle >= DEG_FULL) ? angle - DEG_FULL : angle;
      if (angle_red < DEG_90) begin
         quad = QUAD_0;
         angle_rem = angle_red;
      end else if (angle_red < DEG_180) begin
         quad = QUAD_1;
         angle_rem = angle_red - DEG_90;
      end else if (angle_red < DEG_270) begin
         quad = QUAD_2;
         angle_rem = angle_red - DEG_180;
      end else begin
         quad = QUAD_3;
         angle_rem = angle_red - DEG_270;
      end
   end

   // first quadrant magnitudes from the table
   assign sin_mag = irfm_pkg::sin_deg(angle_rem[irfm_pkg::DEG_W-1:0]);
   assign cos_mag = irfm_pkg::sin_deg(DEG_RIGHT - angle_rem[irfm_pkg::DEG_W-1:0]);
   assign sin_pos = $signed({1'b0, sin_mag});
   assign cos_pos = $signed({1'b0, cos_mag});

   // fold back into the full circle
   always_comb begin
      case (quad)
         QUAD_0: begin
            trig.sin_val = sin_pos;
            trig.cos_val = cos_pos;
         end
         QUAD_1: begin
            trig.sin_val = cos_pos;
            trig.cos_val = -sin_pos;
         end
         QUAD_2: begin
            trig.sin_val = -sin_pos;
            trig.cos_val = -cos_pos;
         end
         QUAD_3: begin
            trig.sin_val = -cos_pos;
            trig.cos_val = sin_pos;
         end
         default: begin
            trig.sin_val = sin_pos;
            trig.cos_val = cos_pos;
         end
      endcase
   end

endmodule

@@ verif/image_rotate_forward_map_unit_tb.sv @@
// self-checking testbench for the image rotate forward map unit
module image_rotate_forward_map_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import irfm_pkg::*;

   // cycles allowed after the last write for pixels that map nowhere
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT = 30;

   // expected destination writes, worked out from its own trig and size registers
   class pixel_mapper;
      rsp_payload_type dest_q[$];
      logic [ANGLE_W-1:0] angle_reg;
      logic [DIM_W-1:0] rows_reg;
      logic [DIM_W-1:0] cols_reg;
      logic signed [TRIG_W-1:0] sin_q16;
      logic signed [TRIG_W-1:0] cos_q16;
      int unsigned pixels_seen;
      int unsigned writes_checked;
      int unsigned errors;

      function new();
         rows_reg = MAX_DIM;
         cols_reg = MAX_DIM;
         pixels_seen = 0;
         writes_checked = 0;
         errors = 0;
         set_angle('0);
      endfunction

      // sine and cosine from a 31-bit series, folded by quadrant
      function void set_angle(logic [ANGLE_W-1:0] deg);
         longint unsigned x, x2, term, s31, c31;
         longint sum;
         int unsigned a, quad, rem;
         logic signed [TRIG_W-1:0] s, c;
         int k;
         angle_reg = deg;
         a = deg % 360;
         quad = a / 90;
         rem = a % 90;
         // radians in q31: rem * pi / 180
         x = (longint'(rem) * 64'd6746518852) / 64'd180;
         x2 = (x * x) >> 31;
         term = x;
         sum = longint'(x);
         for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 31) / (2 * k * (2 * k + 1));
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         s31 = longint'(sum);
         term = 64'd1 << 31;
         sum = longint'(term);
         for (k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 31) / ((2 * k - 1) * (2 * k));
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         c31 = longint'(sum);
         // right angles are exact
         if (rem == 0) begin
            s31 = 0;
            c31 = 64'd1 << 31;
         end
         s = TRIG_W'((s31 + (64'd1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS));
         c = TRIG_W'((c31 + (64'd1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS));
         case (quad)
            0: begin
               sin_q16 = s;
               cos_q16 = c;
            end
            1: begin
               sin_q16 = c;
               cos_q16 = -s;
            end
            2: begin
               sin_q16 = -s;
               cos_q16 = -c;
            end
            default: begin
               sin_q16 = -c;
               cos_q16 = s;
            end
         endcase
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_ANGLE: set_angle(val[ANGLE_W-1:0]);
            CSR_ROWS: rows_reg = val;
            CSR_COLS: cols_reg = val;
            default: ;
         endcase
      endfunction

      // truncate toward zero
      function longint drop_frac(longint n);
         if (n >= 0) return n >>> TRIG_FRAC_BITS;
         return -((-n) >>> TRIG_FRAC_BITS);
      endfunction

      // map one accepted source pixel, queue a write if it lands in the image
      function void note_pixel(req_payload_type p);
         longint eff_rows, eff_cols, row, col, cy, cx, xo, yo, ni, nj;
         rsp_payload_type d;
         pixels_seen++;
         eff_rows = longint'((rows_reg > MAX_DIM) ? MAX_DIM : rows_reg);
         eff_cols = longint'((cols_reg > MAX_DIM) ? MAX_DIM : cols_reg);
         row = longint'(p.src_row);
         col = longint'(p.src_col);
         if (row >= eff_rows || col >= eff_cols) return;
         cy = eff_rows / 2;
         cx = eff_cols / 2;
         xo = col - cx;
         yo = row - cy;
         ni = drop_frac(-xo * longint'(sin_q16) + yo * longint'(cos_q16)
                        + (cy <<< TRIG_FRAC_BITS));
         nj = drop_frac(xo * longint'(cos_q16) + yo * longint'(sin_q16)
                        + (cx <<< TRIG_FRAC_BITS));
         if (ni < 0 || ni >= eff_rows || nj < 0 || nj >= eff_cols) return;
         d.dest_row = ni[COORD_W-1:0];
         d.dest_col = nj[COORD_W-1:0];
         d.pixel_out = p.pixel_value;
         dest_q.push_back(d);
      endfunction

      function int pending();
         return dest_q.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      // compare a write against the oldest expected one
      task check_write(rsp_payload_type got);
         rsp_payload_type want;
         if (dest_q.size() == 0) begin
            report_mismatch($sformatf("unexpected write to row %0d col %0d pixel %06h",
                                      got.dest_row, got.dest_col, got.pixel_out));
            return;
         end
         want = dest_q.pop_front();
         writes_checked++;
         if (got.dest_row !== want.dest_row)
            report_mismatch($sformatf("dest_row %0d, expected %0d",
                                      got.dest_row, want.dest_row));
         if (got.dest_col !== want.dest_col)
            report_mismatch($sformatf("dest_col %0d, expected %0d",
                                      got.dest_col, want.dest_col));
         if (got.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("pixel_out %06h, expected %06h",
                                      got.pixel_out, want.pixel_out));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pixel_mapper mapper = new();
   logic stall_on = 1'b0;
   int stall_left = 0;
   bit gap_on;
   int unsigned settings_done;

   image_rotate_forward_map_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || !stall_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 6) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watch both handshakes
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) mapper.note_pixel(req_payload);
      if (!reset && rsp_valid && !rsp_stall) mapper.check_write(rsp_payload);
   end

   // offer one request, possibly after a gap, and hold it until taken
   task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                             input logic [PIX_W-1:0] pix);
      req_payload_type p;
      p.src_row = row;
      p.src_col = col;
      p.pixel_value = pix;
      if (gap_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   // hold requests until every expected write is out, then let the pipe empty
   task automatic drain_writes();
      req_valid <= 1'b0;
      do @(posedge clock); while (mapper.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers on an idle block
   task automatic apply_setting(input logic [ANGLE_W-1:0] angle,
                                input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
      drain_writes();
      csr_write <= 1'b1;
      csr_index <= CSR_ANGLE;
      csr_wdata <= CSR_DATA_W'(angle);
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_write <= 1'b0;
      mapper.write_reg(CSR_ANGLE, CSR_DATA_W'(angle));
      mapper.write_reg(CSR_ROWS, rows);
      mapper.write_reg(CSR_COLS, cols);
      settings_done++;
   endtask

   // image side: small, up to the limit, exactly the limit, or anything the field holds
   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 3))
         0: return DIM_W'($urandom_range(1, 64));
         1: return DIM_W'($urandom_range(1, 4096));
         2: return MAX_DIM;
         default: return DIM_W'($urandom_range(0, 8191));
      endcase
   endfunction

   // stimulus
   initial begin
      int phase, n;
      logic [ANGLE_W-1:0] ang;
      logic [DIM_W-1:0] nr, nc;
      int unsigned eff_r, eff_c;
      logic [COORD_W-1:0] row, col;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_ANGLE;
      csr_wdata <= '0;
      settings_done = 0;
      gap_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      stall_on <= 1'b1;
      @(posedge clock);

      // reset values: angle zero on a full-size image
      send_pixel(12'd0, 12'd0, 24'h000000);
      send_pixel(12'd4095, 12'd4095, 24'hffffff);
      send_pixel(12'd2048, 12'd2048, 24'h5a5a5a);
      send_pixel(12'haaa, 12'h555, 24'ha5a5a5);

      // quarter turn on a small image, sources on and past the edges
      apply_setting(9'd90, 13'd6, 13'd8);
      send_pixel(12'd0, 12'd0, 24'h010203);
      send_pixel(12'd5, 12'd7, 24'h102030);
      send_pixel(12'd3, 12'd4, 24'h800001);
      send_pixel(12'd6, 12'd0, 24'h123456);
      send_pixel(12'd0, 12'd8, 24'h654321);
      send_pixel(12'd4095, 12'd4095, 24'hfedcba);

      // angle past a full turn, sizes past the limit
      apply_setting(9'd450, 13'd8191, 13'd8191);
      send_pixel(12'd4095, 12'd0, 24'h0f0f0f);
      send_pixel(12'd0, 12'd4095, 24'hf0f0f0);
      send_pixel(12'd100, 12'd3000, 24'h777777);

      // 45 degrees: corners fall off the image
      apply_setting(9'd45, 13'd10, 13'd10);
      send_pixel(12'd0, 12'd0, 24'h111111);
      send_pixel(12'd9, 12'd9, 24'h222222);
      send_pixel(12'd0, 12'd9, 24'h333333);
      send_pixel(12'd9, 12'd0, 24'h444444);
      send_pixel(12'd5, 12'd5, 24'h555555);

      // zero rows drops everything
      apply_setting(9'd180, 13'd0, 13'd4096);
      send_pixel(12'd0, 12'd0, 24'h999999);
      send_pixel(12'd1, 12'd1, 24'haaaaaa);

      // single pixel image at three quarters
      apply_setting(9'd270, 13'd1, 13'd1);
      send_pixel(12'd0, 12'd0, 24'hbbbbbb);
      send_pixel(12'd0, 12'd1, 24'hcccccc);

      // random phases, extreme settings first, the last ones with no idling
      for (phase = 0; phase < 16; phase++) begin
         case (phase)
            0: begin
               ang = 9'd0;
               nr = MAX_DIM;
               nc = MAX_DIM;
            end
            1: begin
               ang = 9'd359;
               nr = 13'd1;
               nc = 13'd1;
            end
            2: begin
               ang = 9'd511;
               nr = 13'd8191;
               nc = 13'd8191;
            end
            3: begin
               ang = 9'd180;
               nr = MAX_DIM;
               nc = 13'd2;
            end
            default: begin
               ang = ANGLE_W'($urandom_range(0, 511));
               nr = pick_dim();
               nc = pick_dim();
            end
         endcase
         apply_setting(ang, nr, nc);
         gap_on = (phase < 14) && ($urandom_range(0, 3) != 0);
         stall_on <= (phase < 14) && ($urandom_range(0, 3) != 0);
         eff_r = (nr > MAX_DIM) ? MAX_DIM : nr;
         eff_c = (nc > MAX_DIM) ? MAX_DIM : nc;
         for (n = 0; n < 120; n++) begin
            // mostly sources inside the image, the rest anywhere
            if (eff_r != 0 && $urandom_range(0, 4) != 0)
               row = COORD_W'($urandom_range(0, eff_r - 1));
            else
               row = COORD_W'($urandom);
            if (eff_c != 0 && $urandom_range(0, 4) != 0)
               col = COORD_W'($urandom_range(0, eff_c - 1));
            else
               col = COORD_W'($urandom);
            send_pixel(row, col, PIX_W'($urandom));
         end
      end

      drain_writes();
      $display("%0d source pixels sent over %0d register settings, %0d writes checked",
               mapper.pixels_seen, settings_done, mapper.writes_checked);
      $display("covered right and odd angles, sizes from zero past the limit, edge sources");
      if (mapper.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("timeout waiting for the block");
      $display("Test completed with failures");
      $finish;
   end

endmodule
